@@ hdl/kxbsc_pkg.sv @@
// Shared types, constants and helper functions for the keyed XOR byte stream cipher.
// Used by kxbsc_pos_track and keyed_xor_byte_stream_cipher; depends on nothing else.
package kxbsc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] RegSlotKeyLow  = 3'd0;
    localparam logic [2:0] RegSlotKeyHigh = 3'd1;
    localparam logic [2:0] RegFileKeyLow  = 3'd2;
    localparam logic [2:0] RegFileKeyHigh = 3'd3;
    localparam logic [2:0] RegEncryptMode = 3'd4;

    // The file key repeats every 17 bytes; its last byte is fixed.
    localparam logic [4:0] FileKeyLastIdx = 5'd16;
    localparam logic [7:0] FileKeyTail    = 8'h6b;

    // Position data that one word needs to build its key bytes.
    typedef struct packed {
        logic [31:0] pos_low;   // low 32 bits of the stream position
        logic [4:0]  file_idx;  // stream position mod 17
    } pos_info_t;

    // Residue of a 64-bit value mod 17. Since 256 = 1 mod 17 the bytes are
    // summed, and since 16 = -1 mod 17 the final byte is low nibble minus
    // high nibble.
    function automatic logic [4:0] mod17_64(input logic [63:0] v);
        logic [10:0] sum;
        logic [8:0]  fold;
        logic [5:0]  t;
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + 11'(v[8*i +: 8]);
        end
        fold = 9'(sum[7:0]) + 9'(sum[10:8]);
        t = 6'(fold[3:0]) + 6'(fold[8]) + 6'd17 - 6'(fold[7:4]);
        if (t >= 6'd17) begin
            return 5'(t - 6'd17);
        end
        return 5'(t);
    endfunction

    // Shear step v ^= v << 4 within one byte; it is its own inverse.
    function automatic logic [7:0] shear(input logic [7:0] v);
        return v ^ {v[3:0], 4'h0};
    endfunction

    // Offset key: XOR of the four low bytes of the position.
    function automatic logic [7:0] offset_mix(input logic [31:0] p);
        return p[7:0] ^ p[15:8] ^ p[23:16] ^ p[31:24];
    endfunction

endpackage

@@ hdl/kxbsc_pos_track.sv @@
// Stream position tracker: running 64-bit position and its residue mod 17.
// Depends on kxbsc_pkg.
module kxbsc_pos_track (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  run_start,
    input  logic [63:0]           start_offset,
    output kxbsc_pkg::pos_info_t  info
);

    logic [63:0] pos_reg, pos_next, pos_cur;
    logic [4:0]  idx_reg, idx_next, idx_cur;

    // Position of the current word: a run start reloads it.
    always_comb begin
        if (run_start) begin
            pos_cur = start_offset;
            idx_cur = kxbsc_pkg::mod17_64(start_offset);
        end else begin
            pos_cur = pos_reg;
            idx_cur = idx_reg;
        end
        info.pos_low = pos_cur[31:0];
        info.file_idx = idx_cur;
    end

    // Step to the next position; the residue wraps with the position.
    always_comb begin
        pos_next = pos_reg;
        idx_next = idx_reg;
        if (advance) begin
            pos_next = pos_cur + 64'd1;
            if (idx_cur == kxbsc_pkg::FileKeyLastIdx) begin
                idx_next = '0;
            end else begin
                idx_next = idx_cur + 5'd1;
            end
            // 2^64 = 1 mod 17, so on wrap the residue must restart at zero.
            if (pos_cur == '1) begin
                idx_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            idx_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
        end
    end

endmodule

@@ hdl/keyed_xor_byte_stream_cipher.sv @@
// Keyed XOR byte stream cipher, top level: input stage, key selection, output stage.
// Depends on kxbsc_pkg and kxbsc_pos_track.
// Two stages: an accepted word is held in the input stage, then in the output stage on m_valid.
// Throughput: one word per cycle without back-pressure; a stalled output still lets s1 fill.
// Reset (aresetn, synchronous, active low) clears keys, mode, stream position and valid flags.
module keyed_xor_byte_stream_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_in,
    input  logic        s_run_start,
    input  logic [63:0] s_start_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_out
);

    logic [63:0] slot_lo_reg, slot_hi_reg, file_lo_reg, file_hi_reg;
    logic        enc_reg;

    logic                 s1_vld_reg, s1_vld_next;
    logic [7:0]           s1_data_reg;
    kxbsc_pkg::pos_info_t s1_info_reg;
    logic                 out_vld_reg, out_vld_next;
    logic [7:0]           out_data_reg;

    logic                 out_free, s1_adv, in_acc;
    kxbsc_pkg::pos_info_t in_info;
    logic [7:0]           slot_kbyte, file_kbyte, off_key, xform;
    logic [127:0]         slot_bytes, file_bytes;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_lo_reg <= '0;
            slot_hi_reg <= '0;
            file_lo_reg <= '0;
            file_hi_reg <= '0;
            enc_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kxbsc_pkg::RegSlotKeyLow:  slot_lo_reg <= cfg_wr_data;
                kxbsc_pkg::RegSlotKeyHigh: slot_hi_reg <= cfg_wr_data;
                kxbsc_pkg::RegFileKeyLow:  file_lo_reg <= cfg_wr_data;
                kxbsc_pkg::RegFileKeyHigh: file_hi_reg <= cfg_wr_data;
                kxbsc_pkg::RegEncryptMode: enc_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: each stage moves when the one after it has room.
    assign out_free = !out_vld_reg || m_ready;
    assign s1_adv   = s1_vld_reg && out_free;
    assign s_ready  = !s1_vld_reg || out_free;
    assign in_acc   = s_valid && s_ready;

    kxbsc_pos_track u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (in_acc),
        .run_start    (s_run_start),
        .start_offset (s_start_offset),
        .info         (in_info)
    );

    // Key bytes for the word in the input stage.
    always_comb begin
        slot_bytes = {slot_hi_reg, slot_lo_reg};
        file_bytes = {file_hi_reg, file_lo_reg};
        slot_kbyte = slot_bytes[{s1_info_reg.pos_low[3:0], 3'b000} +: 8];
        if (s1_info_reg.file_idx == kxbsc_pkg::FileKeyLastIdx) begin
            file_kbyte = kxbsc_pkg::FileKeyTail;
        end else begin
            file_kbyte = file_bytes[{s1_info_reg.file_idx[3:0], 3'b000} +: 8];
        end
        off_key = kxbsc_pkg::offset_mix(s1_info_reg.pos_low);
    end

    // Encrypt runs the decrypt steps in reverse order.
    always_comb begin
        if (enc_reg) begin
            xform = kxbsc_pkg::shear(s1_data_reg ^ off_key ^ slot_kbyte) ^ file_kbyte;
        end else begin
            xform = kxbsc_pkg::shear(s1_data_reg ^ file_kbyte) ^ slot_kbyte ^ off_key;
        end
    end

    // Valid flags of both stages.
    always_comb begin
        s1_vld_next = s1_vld_reg;
        if (in_acc) begin
            s1_vld_next = 1'b1;
        end else if (s1_adv) begin
            s1_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (s1_adv) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_data_reg <= s_data_in;
            s1_info_reg <= in_info;
        end
        if (s1_adv) begin
            out_data_reg <= xform;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_data_out = out_data_reg;

    // The tracked residue never leaves the range of the file key period.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_info.file_idx <= kxbsc_pkg::FileKeyLastIdx)
        else $error("file key index out of range");

    // A word held in the input stage under back-pressure keeps its position data.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg && !out_free |=> s1_vld_reg && $stable(s1_info_reg) && $stable(s1_data_reg))
        else $error("input stage lost its word while stalled");

    // A word leaving the input stage always lands in the output stage.
    a_s1_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> out_vld_reg)
        else $error("word dropped between stages");

endmodule
